// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
// CBP_ASSERT is off while rst_n is low; CBP_ASSERT_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBP_ASSERT(lbl, prop, msg)
`define CBP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/cbp_pkg.sv =====
package cbp_pkg;

  localparam int PW    = 16;  // coordinate width, Q7.8
  localparam int CW    = 20;  // power-basis coefficient width
  localparam int QW    = 17;  // quotient bits, enough for magnitude 32768
  localparam int DIVCW = 5;   // divider step counter
  localparam int CFGW  = 7;

  localparam logic [CFGW-1:0] CFG_RESET   = 7'd64;
  localparam logic [CFGW-1:0] CFG_MIN_PTS = 7'd2;
  localparam logic [QW-1:0]   SAT_POS_MAG = 17'd32767;
  localparam logic [QW-1:0]   SAT_NEG_MAG = 17'd32768;
  localparam logic signed [PW-1:0] PT_MAX = 16'sh7fff;
  localparam logic signed [PW-1:0] PT_MIN = 16'sh8000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_NUM,
    ST_DLOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PREP1,
    OP_PREP2,
    OP_PREP3,
    OP_H1,
    OP_H2,
    OP_H3,
    OP_NUM,
    OP_DLOAD,
    OP_DIV,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic   load;
    logic   cfg_we;
    dp_op_t op;
  } cmd_t;

endpackage

// ===== rtl/cubic_bezier_point_generator_unit.sv =====
// Channel   Transaction when                Payload
// input     start && !busy at clk edge      in_ctrl_x0..in_ctrl_y3
// result    out_valid high for one cycle    out_point_x, out_point_y, out_last_point
// config    cfg_valid && cfg_ready          cfg_points_per_curve
//
// After acceptance a segment is set up once (PREP1..PREP3); a new segment can be
// taken in the cycle busy drops.
// Per point: 3 Horner steps, rounding (NUM), divider load (DLOAD), a bit-serial
// divide by d^3 for the 17 quotient bits, and 1 emit.
// rst_n is synchronous; points_per_curve resets to 64. Config is taken only when idle.
// The receiver cannot stall: each point is shown for exactly one cycle.
module cubic_bezier_point_generator_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_x0,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_y0,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_x1,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_y1,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_x2,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_y2,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_x3,
  input  logic signed [cbp_pkg::PW-1:0]   in_ctrl_y3,
  output logic                            out_valid,
  output logic signed [cbp_pkg::PW-1:0]   out_point_x,
  output logic signed [cbp_pkg::PW-1:0]   out_point_y,
  output logic                            out_last_point,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbp_pkg::CFGW-1:0]        cfg_points_per_curve
);
  import cbp_pkg::*;

  cmd_t cmd;
  logic last_j;

  cbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .last_j    (last_j),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cbp_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_data   (cfg_points_per_curve),
    .ctrl_x0    (in_ctrl_x0),
    .ctrl_y0    (in_ctrl_y0),
    .ctrl_x1    (in_ctrl_x1),
    .ctrl_y1    (in_ctrl_y1),
    .ctrl_x2    (in_ctrl_x2),
    .ctrl_y2    (in_ctrl_y2),
    .ctrl_x3    (in_ctrl_x3),
    .ctrl_y3    (in_ctrl_y3),
    .last_j     (last_j),
    .point_x    (out_point_x),
    .point_y    (out_point_y),
    .last_point (out_last_point)
  );

endmodule

// ===== rtl/cbp_axis.sv =====
// One coordinate axis: coefficients, Horner evaluation on a shared multiplier,
// rounding and a restoring divider (one quotient bit per cycle).
module cbp_axis #(
  parameter int DW = 6
) (
  input  logic                          clk,
  input  logic                          load,
  input  cbp_pkg::dp_op_t               op,
  input  logic signed [cbp_pkg::PW-1:0] p0,
  input  logic signed [cbp_pkg::PW-1:0] p1,
  input  logic signed [cbp_pkg::PW-1:0] p2,
  input  logic signed [cbp_pkg::PW-1:0] p3,
  input  logic [DW-1:0]                 j,
  input  logic [DW-1:0]                 d,
  input  logic [2*DW-1:0]               d2,
  input  logic [3*DW-1:0]               d3,
  output logic signed [cbp_pkg::PW-1:0] point
);
  import cbp_pkg::*;

  localparam int D3W = 3 * DW;
  localparam int AW  = CW + 3 * DW + 3;
  localparam int NW  = AW + 1;
  localparam int RW  = D3W + 1;

  logic signed [CW-1:0] e0, e1, e2, e3, t0, t1, t2;
  logic signed [CW-1:0] c3_r, c2_r, c1_r, c0_r;
  logic signed [AW-1:0] c2d_r, c1dd_r, c0ddd_r, acc_r;
  logic signed [AW-1:0] mul_a, addend, sum;
  logic signed [D3W:0]  mul_b;
  logic signed [AW+D3W:0] prod;
  logic signed [NW-1:0] acc2, d3s, num_s;
  logic [NW-1:0]        num_r, lim;
  logic [RW-1:0]        dd, rem_r;
  logic [RW:0]          sh, diff;
  logic                 ge;
  logic [QW-1:0]        quo_r;
  logic                 neg_r, ovf_r;
  logic signed [PW-1:0] point_r, sat;

  assign e0 = CW'(p0);
  assign e1 = CW'(p1);
  assign e2 = CW'(p2);
  assign e3 = CW'(p3);
  assign t0 = e0 + (e0 <<< 1);
  assign t1 = e1 + (e1 <<< 1);
  assign t2 = e2 + (e2 <<< 1);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    addend = '0;
    unique case (op)
      OP_PREP1: begin
        mul_a = AW'(c2_r);
        mul_b = $signed({1'b0, D3W'(d)});
      end
      OP_PREP2: begin
        mul_a = AW'(c1_r);
        mul_b = $signed({1'b0, D3W'(d2)});
      end
      OP_PREP3: begin
        mul_a = AW'(c0_r);
        mul_b = $signed({1'b0, d3});
      end
      OP_H1: begin
        mul_a  = AW'(c3_r);
        mul_b  = $signed({1'b0, D3W'(j)});
        addend = c2d_r;
      end
      OP_H2: begin
        mul_a  = acc_r;
        mul_b  = $signed({1'b0, D3W'(j)});
        addend = c1dd_r;
      end
      OP_H3: begin
        mul_a  = acc_r;
        mul_b  = $signed({1'b0, D3W'(j)});
        addend = c0ddd_r;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = $signed(prod[AW-1:0]) + addend;

  // 2|num| + d^3 and 2 d^3 give round-half-away-from-zero as a plain floor
  assign acc2  = {acc_r, 1'b0};
  assign d3s   = $signed({{(NW-D3W){1'b0}}, d3});
  assign num_s = acc_r[AW-1] ? (d3s - acc2) : (d3s + acc2);
  assign dd    = {d3, 1'b0};
  assign lim   = {{(NW-RW-QW){1'b0}}, dd, {QW{1'b0}}};

  assign sh   = {rem_r, quo_r[QW-1]};
  assign diff = sh - {1'b0, dd};
  assign ge   = (sh >= {1'b0, dd});

  always_comb begin
    if (neg_r) begin
      sat = (ovf_r || quo_r > SAT_NEG_MAG) ? PT_MIN : -$signed(quo_r[PW-1:0]);
    end else begin
      sat = (ovf_r || quo_r > SAT_POS_MAG) ? PT_MAX : $signed(quo_r[PW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c3_r <= t1 - t2 + e3 - e0;
      c2_r <= t0 - (t1 <<< 1) + t2;
      c1_r <= t1 - t0;
      c0_r <= e0;
    end
    unique case (op)
      OP_PREP1: c2d_r   <= sum;
      OP_PREP2: c1dd_r  <= sum;
      OP_PREP3: c0ddd_r <= sum;
      OP_H1, OP_H2, OP_H3: acc_r <= sum;
      OP_NUM: begin
        num_r <= $unsigned(num_s);
        neg_r <= acc_r[AW-1];
      end
      OP_DLOAD: begin
        ovf_r <= (num_r >= lim);
        rem_r <= num_r[QW +: RW];
        quo_r <= num_r[QW-1:0];
      end
      OP_DIV: begin
        rem_r <= ge ? diff[RW-1:0] : sh[RW-1:0];
        quo_r <= {quo_r[QW-2:0], ge};
      end
      OP_EMIT: point_r <= sat;
      default: ;
    endcase
  end

  assign point = point_r;

endmodule

// ===== rtl/cbp_datapath.sv =====
// Point-count register, shared d, d^2, d^3 and point index, two axis lanes.
module cbp_datapath #(
  parameter int MAX_POINTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cbp_pkg::cmd_t                   cmd,
  input  logic [cbp_pkg::CFGW-1:0]        cfg_data,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_x0,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_y0,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_x1,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_y1,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_x2,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_y2,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_x3,
  input  logic signed [cbp_pkg::PW-1:0]   ctrl_y3,
  output logic                            last_j,
  output logic signed [cbp_pkg::PW-1:0]   point_x,
  output logic signed [cbp_pkg::PW-1:0]   point_y,
  output logic                            last_point
);
  import cbp_pkg::*;

  localparam int DW = $clog2(MAX_POINTS);

  logic [CFGW-1:0]  n_r, n_eff;
  logic [DW-1:0]    d, j_r;
  logic [2*DW-1:0]  d2_r, d_sq;
  logic [3*DW-1:0]  d3_r, d_cu;
  logic             last_r;

  always_comb begin
    priority if (n_r < CFG_MIN_PTS) begin
      n_eff = CFG_MIN_PTS;
    end else if (n_r > CFGW'(MAX_POINTS)) begin
      n_eff = CFGW'(MAX_POINTS);
    end else begin
      n_eff = n_r;
    end
  end

  assign d      = DW'(n_eff - CFGW'(1));
  assign d_sq   = d * d;
  assign d_cu   = d2_r * d;
  assign last_j = (j_r == d);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= CFG_RESET;
    end else if (cmd.cfg_we) begin
      n_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      j_r <= '0;
    end
    unique case (cmd.op)
      OP_PREP1: d2_r <= d_sq;
      OP_PREP2: d3_r <= d_cu;
      OP_EMIT: begin
        j_r    <= j_r + DW'(1);
        last_r <= last_j;
      end
      default: ;
    endcase
  end

  cbp_axis #(.DW(DW)) u_axis_x (
    .clk   (clk),
    .load  (cmd.load),
    .op    (cmd.op),
    .p0    (ctrl_x0),
    .p1    (ctrl_x1),
    .p2    (ctrl_x2),
    .p3    (ctrl_x3),
    .j     (j_r),
    .d     (d),
    .d2    (d2_r),
    .d3    (d3_r),
    .point (point_x)
  );

  cbp_axis #(.DW(DW)) u_axis_y (
    .clk   (clk),
    .load  (cmd.load),
    .op    (cmd.op),
    .p0    (ctrl_y0),
    .p1    (ctrl_y1),
    .p2    (ctrl_y2),
    .p3    (ctrl_y3),
    .j     (j_r),
    .d     (d),
    .d2    (d2_r),
    .d3    (d3_r),
    .point (point_y)
  );

  assign last_point = last_r;

endmodule

// ===== rtl/cbp_ctrl.sv =====
`include "assert_macros.svh"

// Sequencer: per-segment setup, then per point Horner, rounding, divide, emit.
module cbp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          cfg_valid,
  input  logic          last_j,
  output logic          busy,
  output logic          cfg_ready,
  output logic          out_valid,
  output cbp_pkg::cmd_t cmd
);
  import cbp_pkg::*;

  state_t           state_r, state_nxt;
  logic [DIVCW-1:0] div_cnt_r, div_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = (state_r == ST_EMIT);
    cmd.load      = 1'b0;
    cmd.cfg_we    = cfg_valid && (state_r == ST_IDLE);
    cmd.op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP1;
        end
      end
      ST_PREP1: begin
        cmd.op    = OP_PREP1;
        state_nxt = ST_PREP2;
      end
      ST_PREP2: begin
        cmd.op    = OP_PREP2;
        state_nxt = ST_PREP3;
      end
      ST_PREP3: begin
        cmd.op    = OP_PREP3;
        state_nxt = ST_H1;
      end
      ST_H1: begin
        cmd.op    = OP_H1;
        state_nxt = ST_H2;
      end
      ST_H2: begin
        cmd.op    = OP_H2;
        state_nxt = ST_H3;
      end
      ST_H3: begin
        cmd.op    = OP_H3;
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        cmd.op    = OP_NUM;
        state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.op      = OP_DLOAD;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.op      = OP_DIV;
        div_cnt_nxt = div_cnt_r + DIVCW'(1);
        if (div_cnt_r == DIVCW'(QW - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = last_j ? ST_IDLE : ST_H1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `CBP_ASSERT(a_strobe_after_emit, out_valid_r |-> $past(state_r == ST_EMIT), "strobe without emit")
  `CBP_ASSERT(a_accept_starts, (start && state_r == ST_IDLE) |=> state_r == ST_PREP1, "accept lost")
  `CBP_ASSERT(a_div_len, (state_r == ST_DIV && div_cnt_r != DIVCW'(QW - 1)) |=> state_r == ST_DIV, "divide cut short")
  `CBP_ASSERT(a_last_ends, (state_r == ST_EMIT && last_j) |=> (state_r == ST_IDLE && out_valid_r), "last point did not end segment")
  `CBP_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid_r, "strobe after reset")

endmodule

// ===== test/cbp_checker.sv =====
module cbp_checker #(
  parameter int MAX_PTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_x0,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_y0,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_x1,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_y1,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_x2,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_y2,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_x3,
  input  logic signed [cbp_pkg::PW-1:0] in_ctrl_y3,
  input  logic                          out_valid,
  input  logic signed [cbp_pkg::PW-1:0] out_point_x,
  input  logic signed [cbp_pkg::PW-1:0] out_point_y,
  input  logic                          out_last_point,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cbp_pkg::CFGW-1:0]      cfg_points_per_curve,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbp_pkg::*;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic                 last;
  } point_t;

  point_t          point_q[$];
  logic [CFGW-1:0] pts_reg;
  int              mism = 0;

  assign fail_count = mism;

  // Horner evaluation at t = j/d kept as an exact ratio, then divided by d^3
  // with round half away from zero and clamped to Q7.8.
  function automatic logic signed [PW-1:0] bezier_coord(input longint p0, input longint p1,
                                                        input longint p2, input longint p3,
                                                        input longint j, input longint d);
    longint c3, c2, c1, num, den, mag, q;
    c3  = -p0 + 3 * p1 - 3 * p2 + p3;
    c2  = 3 * p0 - 6 * p1 + 3 * p2;
    c1  = -3 * p0 + 3 * p1;
    num = ((c3 * j + c2 * d) * j + c1 * d * d) * j + p0 * d * d * d;
    den = d * d * d;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + den) / (2 * den);
    if (num < 0) begin
      return (q > 32768) ? PT_MIN : PW'(-q);
    end
    return (q > 32767) ? PT_MAX : PW'(q);
  endfunction

  task automatic flag(input string what);
    $display("%0t ns: %s", $realtime, what);
    mism++;
  endtask

  always @(posedge clk) begin
    point_t want;
    int     n;
    if (!rst_n) begin
      pts_reg = CFG_RESET;
      point_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        pts_reg = cfg_points_per_curve;
      end
      if (start && !busy) begin
        n = (pts_reg < CFG_MIN_PTS) ? int'(CFG_MIN_PTS) :
            (pts_reg > MAX_PTS) ? MAX_PTS : int'(pts_reg);
        for (int j = 0; j < n; j++) begin
          point_q.push_back('{
            x:    bezier_coord(in_ctrl_x0, in_ctrl_x1, in_ctrl_x2, in_ctrl_x3, j, n - 1),
            y:    bezier_coord(in_ctrl_y0, in_ctrl_y1, in_ctrl_y2, in_ctrl_y3, j, n - 1),
            last: (j == n - 1)
          });
        end
      end
      if (out_valid) begin
        if (point_q.size() == 0) begin
          flag($sformatf("point (%0d,%0d) with no transaction pending",
                         out_point_x, out_point_y));
        end else begin
          want = point_q.pop_front();
          if (out_point_x !== want.x) begin
            flag($sformatf("point_x %0d, expected %0d", out_point_x, want.x));
          end
          if (out_point_y !== want.y) begin
            flag($sformatf("point_y %0d, expected %0d", out_point_y, want.y));
          end
          if (out_last_point !== want.last) begin
            flag($sformatf("last_point %0b, expected %0b", out_last_point, want.last));
          end
        end
      end
    end
    pending <= point_q.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cbp_pkg::*;

  typedef struct packed {
    logic signed [PW-1:0] x0;
    logic signed [PW-1:0] y0;
    logic signed [PW-1:0] x1;
    logic signed [PW-1:0] y1;
    logic signed [PW-1:0] x2;
    logic signed [PW-1:0] y2;
    logic signed [PW-1:0] x3;
    logic signed [PW-1:0] y3;
  } seg_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [PW-1:0] in_ctrl_x0 = '0;
  logic signed [PW-1:0] in_ctrl_y0 = '0;
  logic signed [PW-1:0] in_ctrl_x1 = '0;
  logic signed [PW-1:0] in_ctrl_y1 = '0;
  logic signed [PW-1:0] in_ctrl_x2 = '0;
  logic signed [PW-1:0] in_ctrl_y2 = '0;
  logic signed [PW-1:0] in_ctrl_x3 = '0;
  logic signed [PW-1:0] in_ctrl_y3 = '0;
  logic                 out_valid;
  logic signed [PW-1:0] out_point_x;
  logic signed [PW-1:0] out_point_y;
  logic                 out_last_point;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFGW-1:0]      cfg_points_per_curve = '0;
  int                   fail_count;
  int                   pending;

  cubic_bezier_point_generator_unit dut (.*);

  cbp_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[cubic_bezier_point_generator_unit] ERROR");
    $finish;
  end

  function automatic logic signed [PW-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return PT_MAX;
      1: return PT_MIN;
      2: return PW'(int'($urandom_range(0, 32)) - 16);
      default: return PW'($urandom);
    endcase
  endfunction

  function automatic seg_t rand_seg();
    return '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
  endfunction

  // mostly back to back, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  task automatic send_seg(input seg_t s, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ctrl_x0 <= s.x0;
    in_ctrl_y0 <= s.y0;
    in_ctrl_x1 <= s.x1;
    in_ctrl_y1 <= s.y1;
    in_ctrl_x2 <= s.x2;
    in_ctrl_y2 <= s.y2;
    in_ctrl_x3 <= s.x3;
    in_ctrl_y3 <= s.y3;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // stop sending until every expected point is out and the unit is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (busy) @(posedge clk);
  endtask

  task automatic write_pts(input logic [CFGW-1:0] v);
    drain();
    cfg_points_per_curve <= v;
    cfg_valid            <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int v, cnt;
    bit burst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset count of 64 points
    send_seg('{PT_MAX, PT_MIN, PT_MIN, PT_MAX, PT_MAX, PT_MIN, PT_MIN, PT_MAX}, 0);
    send_seg(rand_seg(), pick_gap());

    write_pts(7'd4);
    send_seg('0, 0);
    send_seg('{8{PT_MAX}}, 0);
    send_seg('{8{PT_MIN}}, pick_gap());
    send_seg('{PT_MIN, PT_MAX, PT_MAX, PT_MIN, PT_MIN, PT_MAX, PT_MAX, PT_MIN}, 0);
    send_seg('{-16'sd1000, 16'sd200, -16'sd300, 16'sd900,
               16'sd400, 16'sd1600, 16'sd1100, 16'sd2300}, 0);
    send_seg('{16'sd1, -16'sd1, 16'sd0, 16'sd1, -16'sd1, 16'sd0, 16'sd1, -16'sd1}, 0);
    send_seg(rand_seg(), pick_gap());
    send_seg(rand_seg(), 0);

    // midpoint of the first segment lands exactly on half an LSB: rounds away from zero
    write_pts(7'd3);
    send_seg('{16'sd4, -16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0);
    send_seg('{16'sd12, -16'sd12, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4, -16'sd4}, 0);

    // counts below and above the legal range clamp to 2 and 64
    write_pts(7'd0);
    send_seg(rand_seg(), 0);
    send_seg('{PT_MAX, PT_MIN, PT_MAX, PT_MIN, PT_MIN, PT_MAX, PT_MIN, PT_MAX}, 0);
    write_pts(7'd1);
    send_seg(rand_seg(), 0);
    write_pts(7'd127);
    send_seg(rand_seg(), 0);
    write_pts(7'd65);
    send_seg(rand_seg(), 0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: v = 2;
        1: v = 3;
        2: v = $urandom_range(2, 10);
        3: v = $urandom_range(5, 16);
        4: v = 64;
        5: v = $urandom_range(0, 127);
        6: v = 1;
        default: v = $urandom_range(2, 20);
      endcase
      write_pts(CFGW'(v));
      cnt   = (v > 20) ? 3 : 24;
      burst = (ph == 1 || ph == 6);
      for (int k = 0; k < cnt; k++) begin
        if ($urandom_range(0, 14) == 0) drain();
        send_seg(rand_seg(), burst ? 0 : pick_gap());
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[cubic_bezier_point_generator_unit] OK");
    end else begin
      $display("[cubic_bezier_point_generator_unit] ERROR");
    end
    $finish;
  end

endmodule
